### sv/npc_pkg.sv
// Shared types and constants for the nearest palette color block.
`default_nettype none

package npc_pkg;

    // Field widths fixed by the pixel format and register map.
    localparam int unsigned CHAN_W        = 8;
    localparam int unsigned INDEX_W       = 5;
    localparam int unsigned SIZE_W        = 6;
    localparam int unsigned SQ_W          = 2 * CHAN_W;
    localparam int unsigned DIST_W        = SQ_W + 2;
    localparam int unsigned ENTRIES_DEF   = 32;

    // Operation codes carried by the op field.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // One RGB888 color.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    // Distance result of one palette lane.
    typedef struct packed {
        logic              in_use;
        logic [DIST_W-1:0] distance;
        color_t            color;
    } lane_t;

endpackage

`default_nettype wire

### sv/npc_lane.sv
// One palette entry with its two-stage squared distance pipeline.
`default_nettype none

module npc_lane (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic            wr_en,
    input  wire npc_pkg::color_t wr_color,
    input  wire npc_pkg::color_t pix_color,
    input  wire logic            in_use,
    output npc_pkg::lane_t       lane_q
);
    import npc_pkg::*;

    color_t            entry_reg;
    logic [CHAN_W-1:0] dr, dg, db;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    color_t            color_s1_reg;
    logic              use_s1_reg;
    lane_t             lane_reg;

    // Palette entry storage, written when a palette word passes the first stage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_color;
        end
    end

    // Absolute channel differences against the stored entry.
    always_comb
    begin
        dr = (entry_reg.red > pix_color.red) ? entry_reg.red - pix_color.red
                                             : pix_color.red - entry_reg.red;
        dg = (entry_reg.green > pix_color.green) ? entry_reg.green - pix_color.green
                                                 : pix_color.green - entry_reg.green;
        db = (entry_reg.blue > pix_color.blue) ? entry_reg.blue - pix_color.blue
                                               : pix_color.blue - entry_reg.blue;
    end

    // Stage one: per-channel squares, plus the entry color it was measured against.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_r_reg     <= SQ_W'(dr) * SQ_W'(dr);
            sq_g_reg     <= SQ_W'(dg) * SQ_W'(dg);
            sq_b_reg     <= SQ_W'(db) * SQ_W'(db);
            color_s1_reg <= entry_reg;
            use_s1_reg   <= in_use;
        end
    end

    // Stage two: sum of squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg.in_use   <= use_s1_reg;
            lane_reg.distance <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
            lane_reg.color    <= color_s1_reg;
        end
    end

    assign lane_q = lane_reg;

endmodule

`default_nettype wire

### sv/nearest_palette_color.sv
// Nearest palette color, with LEVELS = ceil(log2(PALETTE_ENTRIES)) but at least one.
// Throughput is one word per cycle while out_ready is not holding a finished word.
// Stages: input register, two distance stages per lane,
// one registered compare level per tree level, then the output register.
// Reset clears the valid bits and palette_size; palette contents are undefined
// until written.
`default_nettype none

module nearest_palette_color #(
    parameter int unsigned PALETTE_ENTRIES = npc_pkg::ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [npc_pkg::SIZE_W-1:0]   palette_size,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         op,
    input  wire logic [npc_pkg::INDEX_W-1:0]  entry_index,
    input  wire logic [npc_pkg::CHAN_W-1:0]   red_in,
    input  wire logic [npc_pkg::CHAN_W-1:0]   green_in,
    input  wire logic [npc_pkg::CHAN_W-1:0]   blue_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [npc_pkg::CHAN_W-1:0]        red_out,
    output logic [npc_pkg::CHAN_W-1:0]        green_out,
    output logic [npc_pkg::CHAN_W-1:0]        blue_out,
    output logic [npc_pkg::INDEX_W-1:0]       chosen_index,
    output logic                              passed_through
);
    import npc_pkg::*;

    // Tree geometry: at least one compare level.
    localparam int unsigned LEVELS = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int unsigned LEAVES = 1 << LEVELS;
    localparam int unsigned IW     = LEVELS;
    // Side pipeline depth: two lane stages plus the tree levels.
    localparam int unsigned SIDE   = 2 + LEVELS;

    typedef struct packed {
        logic              in_use;
        logic [DIST_W-1:0] distance;
        logic [IW-1:0]     idx;
        color_t            color;
    } node_t;

    // Left child holds lower indices, so it wins on equal distance.
    function automatic node_t pick(input node_t left, input node_t right);
        node_t res;
        if (left.in_use && (!right.in_use || (left.distance <= right.distance)))
        begin
            res = left;
        end
        else
        begin
            res = right;
        end
        return res;
    endfunction

    logic                 en;
    logic [SIZE_W-1:0]    palette_size_reg;
    logic                 s0_valid_reg;
    logic                 s0_op_reg;
    logic [INDEX_W-1:0]   s0_index_reg;
    color_t               s0_color_reg;
    logic                 s0_write;
    logic                 side_valid_reg [SIDE];
    logic                 side_pass_reg  [SIDE];
    color_t               side_pix_reg   [SIDE];
    node_t                leaf           [LEAVES];
    node_t                node_reg       [1:LEAVES-1];
    logic                 out_valid_reg;
    color_t               out_color_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic                 out_pass_reg;

    // The whole pipeline advances together unless a finished word is held.
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Palette size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg <= '0;
        end
        else if (cfg_valid)
        begin
            palette_size_reg <= palette_size;
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_op_reg          <= op;
            s0_index_reg       <= entry_index;
            s0_color_reg.red   <= red_in;
            s0_color_reg.green <= green_in;
            s0_color_reg.blue  <= blue_in;
        end
    end

    assign s0_write = en && s0_valid_reg && (s0_op_reg == OP_WRITE);

    // Palette lanes; unused leaves of the tree are padded out as not in use.
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < PALETTE_ENTRIES)
        begin : g_lane
            lane_t lane_q;
            logic  wr_hit;
            logic  lane_use;

            if (i < (1 << INDEX_W))
            begin : g_wr
                assign wr_hit = (s0_index_reg == INDEX_W'(i));
            end
            else
            begin : g_nowr
                assign wr_hit = 1'b0;
            end

            if (i < (1 << SIZE_W))
            begin : g_use
                assign lane_use = (palette_size_reg > SIZE_W'(i));
            end
            else
            begin : g_nouse
                assign lane_use = 1'b0;
            end

            npc_lane u_lane (
                .clk       (clk),
                .en        (en),
                .wr_en     (s0_write && wr_hit),
                .wr_color  (s0_color_reg),
                .pix_color (s0_color_reg),
                .in_use    (lane_use),
                .lane_q    (lane_q)
            );

            assign leaf[i] = {lane_q.in_use, lane_q.distance, IW'(i), lane_q.color};
        end
        else
        begin : g_pad
            assign leaf[i] = '0;
        end
    end

    // Registered minimum tree in heap order; node 1 is the root.
    for (genvar j = 1; j < LEAVES; j++)
    begin : g_node
        node_t left_c;
        node_t right_c;

        if (2 * j >= LEAVES)
        begin : g_from_leaf
            assign left_c  = leaf[2 * j - LEAVES];
            assign right_c = leaf[2 * j + 1 - LEAVES];
        end
        else
        begin : g_from_node
            assign left_c  = node_reg[2 * j];
            assign right_c = node_reg[2 * j + 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                node_reg[j] <= pick(left_c, right_c);
            end
        end
    end

    // Side pipeline: pixel valid, pass-through flag and the original pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE; k++)
            begin
                side_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            side_valid_reg[0] <= s0_valid_reg && (s0_op_reg == OP_PIXEL);
            for (int k = 1; k < SIDE; k++)
            begin
                side_valid_reg[k] <= side_valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pass_reg[0] <= (palette_size_reg == '0);
            side_pix_reg[0]  <= s0_color_reg;
            for (int k = 1; k < SIDE; k++)
            begin
                side_pass_reg[k] <= side_pass_reg[k - 1];
                side_pix_reg[k]  <= side_pix_reg[k - 1];
            end
        end
    end

    // Output register: chosen entry or the untouched pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_valid_reg[SIDE - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pass_reg <= side_pass_reg[SIDE - 1];
            if (side_pass_reg[SIDE - 1])
            begin
                out_color_reg <= side_pix_reg[SIDE - 1];
                out_index_reg <= '0;
            end
            else
            begin
                out_color_reg <= node_reg[1].color;
                out_index_reg <= INDEX_W'(node_reg[1].idx);
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign red_out        = out_color_reg.red;
    assign green_out      = out_color_reg.green;
    assign blue_out       = out_color_reg.blue;
    assign chosen_index   = out_index_reg;
    assign passed_through = out_pass_reg;

endmodule

`default_nettype wire
